>>> rtl/hpp_pkg.sv
// Package for the hypotrochoid pen point pipeline: widths, constants, register codes.
// Used by hpp_div, hpp_cordic and hypotrochoid_pen_point_top. No dependencies.
package hpp_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN = 24;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd536870912, 32'd316933407, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    localparam int XY_W = 34;
    localparam int Z_W = 33;
    localparam logic signed [XY_W-1:0] CORDIC_K = 34'sd652032874;

    // Divider: 32-bit dividend, 4 quotient bits per stage.
    localparam int DIV_W = 32;
    localparam int DIV_BPS = 4;
    localparam int DIV_STG = DIV_W / DIV_BPS;

    typedef enum logic [2:0] {
        REG_GUIDE_TEETH = 3'd0,
        REG_WHEEL_TEETH = 3'd1,
        REG_SCALE       = 3'd2,
        REG_CENTER_X    = 3'd3,
        REG_CENTER_Y    = 3'd4
    } cfg_reg_t;

    localparam logic [7:0]  GUIDE_RST = 8'd96;
    localparam logic [7:0]  WHEEL_RST = 8'd36;
    localparam logic [14:0] SCALE_RST = 15'd16384;

    localparam logic signed [19:0] OUT_MIN = -20'sd524288;
    localparam logic signed [19:0] OUT_MAX = 20'sd524287;

endpackage

>>> rtl/hpp_div.sv
// Pipelined restoring divider giving the low 16 quotient bits of num / den.
// Depends on hpp_pkg for the dividend width and bits per stage.
module hpp_div
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [hpp_pkg::DIV_W-1:0]     num,
    input  logic [8:0]                    den,
    input  logic                          neg,
    output logic [15:0]                   quo,
    output logic                          neg_out
);

    logic [hpp_pkg::DIV_W-1:0] num_reg [hpp_pkg::DIV_STG];
    logic [8:0]                rem_reg [hpp_pkg::DIV_STG];
    logic [15:0]               quo_reg [hpp_pkg::DIV_STG];
    logic                      neg_reg [hpp_pkg::DIV_STG];

    for (genvar s = 0; s < hpp_pkg::DIV_STG; s++) begin : g_stage
        logic [hpp_pkg::DIV_W-1:0] num_src;
        logic [8:0]                rem_src;
        logic [15:0]               quo_src;
        logic                      neg_src;
        logic [hpp_pkg::DIV_W-1:0] num_next;
        logic [8:0]                rem_next;
        logic [15:0]               quo_next;

        if (s == 0) begin : g_first
            assign num_src = num;
            assign rem_src = '0;
            assign quo_src = '0;
            assign neg_src = neg;
        end
        else begin : g_rest
            assign num_src = num_reg[s-1];
            assign rem_src = rem_reg[s-1];
            assign quo_src = quo_reg[s-1];
            assign neg_src = neg_reg[s-1];
        end

        always_comb
        begin
            logic [9:0] r2;
            num_next = num_src;
            rem_next = rem_src;
            quo_next = quo_src;
            for (int b = 0; b < hpp_pkg::DIV_BPS; b++)
            begin
                r2 = {rem_next, num_next[hpp_pkg::DIV_W-1]};
                num_next = {num_next[hpp_pkg::DIV_W-2:0], 1'b0};
                if (r2 >= {1'b0, den})
                begin
                    rem_next = 9'(r2 - {1'b0, den});
                    quo_next = {quo_next[14:0], 1'b1};
                end
                else
                begin
                    rem_next = r2[8:0];
                    quo_next = {quo_next[14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s] <= num_next;
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
                neg_reg[s] <= neg_src;
            end
        end
    end

    assign quo     = quo_reg[hpp_pkg::DIV_STG-1];
    assign neg_out = neg_reg[hpp_pkg::DIV_STG-1];

endmodule

>>> rtl/hpp_cordic.sv
// Pipelined rotation-mode CORDIC: cosine and sine (Q30) of a 16-bit turn angle.
// Depends on hpp_pkg for the arctangent table, gain and widths.
module hpp_cordic
#(
    parameter int STAGES = hpp_pkg::CORDIC_STAGES_DEF
)
(
    input  logic                               clk,
    input  logic                               en,
    input  logic [15:0]                        angle,
    output logic signed [hpp_pkg::XY_W-1:0]    cos_out,
    output logic signed [hpp_pkg::XY_W-1:0]    sin_out
);

    logic signed [hpp_pkg::XY_W-1:0] x_reg [STAGES+1];
    logic signed [hpp_pkg::XY_W-1:0] y_reg [STAGES+1];
    logic signed [hpp_pkg::Z_W-1:0]  z_reg [STAGES+1];
    logic [1:0]                      q_reg [STAGES+1];
    logic signed [hpp_pkg::XY_W-1:0] cos_reg;
    logic signed [hpp_pkg::XY_W-1:0] sin_reg;

    logic [15:0] ang_bias;
    logic [1:0]  quad;
    logic [15:0] resid;

    // Reduce to the nearest quarter turn; the residual is kept in 2^-32 turn.
    assign ang_bias = angle + 16'h2000;
    assign quad     = ang_bias[15:14];
    assign resid    = angle - {quad, 14'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= hpp_pkg::CORDIC_K;
            y_reg[0] <= '0;
            z_reg[0] <= hpp_pkg::Z_W'($signed({resid, 16'd0}));
            q_reg[0] <= quad;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        localparam logic signed [hpp_pkg::Z_W-1:0] ATAN_I =
            hpp_pkg::Z_W'(hpp_pkg::ATAN_TAB[i]);
        logic signed [hpp_pkg::XY_W-1:0] dx;
        logic signed [hpp_pkg::XY_W-1:0] dy;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][hpp_pkg::Z_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (q_reg[STAGES])
                2'd0:
                begin
                    cos_reg <= x_reg[STAGES];
                    sin_reg <= y_reg[STAGES];
                end
                2'd1:
                begin
                    cos_reg <= -y_reg[STAGES];
                    sin_reg <= x_reg[STAGES];
                end
                2'd2:
                begin
                    cos_reg <= -x_reg[STAGES];
                    sin_reg <= -y_reg[STAGES];
                end
                default:
                begin
                    cos_reg <= y_reg[STAGES];
                    sin_reg <= -x_reg[STAGES];
                end
            endcase
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

>>> rtl/hypotrochoid_pen_point_top.sv
// Hypotrochoid pen point: one pen position per phase word, fully pipelined.
// Depends on hpp_pkg, hpp_div and hpp_cordic.
//
// Each input word (phase, hole offset) gives one output word (pen x, pen y).
// A new word can enter in every clock cycle unless the pipeline holds; it passes
// through the 8-stage quotient divider for the wheel turn angle, the
// CORDIC pipeline (CORDIC_STAGES + 2 stages, two units side by side) and the
// split multiply, round and saturate stages. The whole pipeline holds when the
// output word is not taken, so s_tready follows m_tready or an empty output.
// Configuration writes are always taken and must happen while the pipe is empty.
module hypotrochoid_pen_point_top
#(
    parameter int CORDIC_STAGES = hpp_pkg::CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // phase_turns[23:0], hole_x[38:24], hole_y[53:39]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pen_x[19:0], pen_y[39:20]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    localparam int XW = hpp_pkg::XY_W;
    localparam int HL = 2 + hpp_pkg::DIV_STG + 1 + CORDIC_STAGES + 2;
    localparam int PL = 2 + hpp_pkg::DIV_STG;
    localparam int TOT = 1 + HL + 6;

    logic [7:0]  guide_reg;
    logic [7:0]  wheel_reg;
    logic [14:0] scale_reg;
    logic [17:0] cx_reg;
    logic [17:0] cy_reg;

    logic en;
    logic vld_reg [TOT];

    assign en        = !vld_reg[TOT-1] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[TOT-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guide_reg <= hpp_pkg::GUIDE_RST;
            wheel_reg <= hpp_pkg::WHEEL_RST;
            scale_reg <= hpp_pkg::SCALE_RST;
            cx_reg    <= '0;
            cy_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (hpp_pkg::cfg_reg_t'(cfg_index))
                hpp_pkg::REG_GUIDE_TEETH: guide_reg <= cfg_data[7:0];
                hpp_pkg::REG_WHEEL_TEETH: wheel_reg <= cfg_data[7:0];
                hpp_pkg::REG_SCALE:       scale_reg <= cfg_data[14:0];
                hpp_pkg::REG_CENTER_X:    cx_reg    <= cfg_data;
                hpp_pkg::REG_CENTER_Y:    cy_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < TOT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Radii from registers the user must change only with the pipe empty; unchecked.
    logic signed [8:0]  gw_diff;
    logic signed [8:0]  wg_diff;
    logic signed [23:0] d_reg;
    logic [22:0]        r_reg;

    assign gw_diff = $signed({1'b0, guide_reg}) - $signed({1'b0, wheel_reg});
    assign wg_diff = $signed({1'b0, wheel_reg}) - $signed({1'b0, guide_reg});

    always_ff @(posedge clk)
    begin
        d_reg <= 24'(gw_diff * $signed({1'b0, scale_reg}));
        r_reg <= 23'(wheel_reg * scale_reg);
    end

    // Input stage and hole offset delay line.
    logic signed [14:0] hx_dly [HL+1];
    logic signed [14:0] hy_dly [HL+1];
    logic [15:0]        ph_dly [PL+1];
    logic signed [23:0] ph0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph0_reg   <= $signed(s_tdata[23:0]);
            ph_dly[0] <= s_tdata[15:0];
            hx_dly[0] <= $signed(s_tdata[38:24]);
            hy_dly[0] <= $signed(s_tdata[53:39]);
            for (int k = 1; k <= HL; k++)
            begin
                hx_dly[k] <= hx_dly[k-1];
                hy_dly[k] <= hy_dly[k-1];
            end
            for (int k = 1; k <= PL; k++)
                ph_dly[k] <= ph_dly[k-1];
        end
    end

    // Wheel turn: round((w - g) * phase / w), done as a floor division by 2w.
    logic signed [31:0] n_reg;
    logic signed [32:0] div_num;
    logic [8:0]         den;
    logic [31:0]        m_reg;
    logic               neg_reg;
    logic [15:0]        quo;
    logic               quo_neg;

    assign den     = {wheel_reg, 1'b0};
    assign div_num = $signed({n_reg, 1'b0}) + $signed({25'd0, wheel_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= 32'(wg_diff * ph0_reg);
            neg_reg <= div_num[32];
            // A negative dividend is divided as a ceiling of its magnitude.
            if (div_num[32])
                m_reg <= 32'(-div_num + $signed({24'd0, den}) - 33'sd1);
            else
                m_reg <= div_num[31:0];
        end
    end

    hpp_div u_div
    (
        .clk     (clk),
        .en      (en),
        .num     (m_reg),
        .den     (den),
        .neg     (neg_reg),
        .quo     (quo),
        .neg_out (quo_neg)
    );

    logic [15:0] ang1_reg;
    logic [15:0] ang2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang1_reg <= ph_dly[PL];
            if (wheel_reg == 8'd0)
                ang2_reg <= '0;
            else if (quo_neg)
                ang2_reg <= -quo;
            else
                ang2_reg <= quo;
        end
    end

    logic signed [XW-1:0] c1;
    logic signed [XW-1:0] s1;
    logic signed [XW-1:0] c2;
    logic signed [XW-1:0] s2;

    hpp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_phase
    (
        .clk     (clk),
        .en      (en),
        .angle   (ang1_reg),
        .cos_out (c1),
        .sin_out (s1)
    );

    hpp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_wheel
    (
        .clk     (clk),
        .en      (en),
        .angle   (ang2_reg),
        .cos_out (c2),
        .sin_out (s2)
    );

    // Hole rotation, rounded back to Q30.
    logic signed [48:0] chx_reg;
    logic signed [48:0] shy_reg;
    logic signed [48:0] shx_reg;
    logic signed [48:0] chy_reg;
    logic signed [XW-1:0] c1_dly [2];
    logic signed [XW-1:0] s1_dly [2];
    logic signed [XW-1:0] ux_reg;
    logic signed [XW-1:0] uy_reg;
    logic signed [49:0]   ux_sum;
    logic signed [49:0]   uy_sum;

    assign ux_sum = 50'(chx_reg) - 50'(shy_reg) + 50'sd8192;
    assign uy_sum = 50'(shx_reg) + 50'(chy_reg) + 50'sd8192;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chx_reg   <= 49'(c2 * hx_dly[HL]);
            shy_reg   <= 49'(s2 * hy_dly[HL]);
            shx_reg   <= 49'(s2 * hx_dly[HL]);
            chy_reg   <= 49'(c2 * hy_dly[HL]);
            c1_dly[0] <= c1;
            s1_dly[0] <= s1;
            c1_dly[1] <= c1_dly[0];
            s1_dly[1] <= s1_dly[0];
            ux_reg    <= ux_sum[47:14];
            uy_reg    <= uy_sum[47:14];
        end
    end

    // Offset products, each split in two halves to keep the multipliers narrow.
    logic signed [24:0] r_s;
    logic signed [41:0] dxl_reg, dxh_reg, dyl_reg, dyh_reg;
    logic signed [41:0] rxl_reg, rxh_reg, ryl_reg, ryh_reg;
    logic signed [59:0] oxa_reg, oxb_reg, oya_reg, oyb_reg;
    logic signed [59:0] tx;
    logic signed [59:0] ty;
    logic signed [19:0] sx_reg;
    logic signed [19:0] sy_reg;

    assign r_s = $signed({2'b0, r_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxl_reg <= 42'(d_reg * $signed({1'b0, c1_dly[1][16:0]}));
            dxh_reg <= 42'(d_reg * $signed(c1_dly[1][XW-1:17]));
            dyl_reg <= 42'(d_reg * $signed({1'b0, s1_dly[1][16:0]}));
            dyh_reg <= 42'(d_reg * $signed(s1_dly[1][XW-1:17]));
            rxl_reg <= 42'(r_s * $signed({1'b0, ux_reg[16:0]}));
            rxh_reg <= 42'(r_s * $signed(ux_reg[XW-1:17]));
            ryl_reg <= 42'(r_s * $signed({1'b0, uy_reg[16:0]}));
            ryh_reg <= 42'(r_s * $signed(uy_reg[XW-1:17]));

            oxa_reg <= (60'(dxh_reg) <<< 17) + 60'(dxl_reg);
            oxb_reg <= (60'(rxh_reg) <<< 17) + 60'(rxl_reg);
            oya_reg <= (60'(dyh_reg) <<< 17) + 60'(dyl_reg);
            oyb_reg <= (60'(ryh_reg) <<< 17) + 60'(ryl_reg);

            sx_reg <= tx[59:40];
            sy_reg <= ty[59:40];
        end
    end

    // Round to nearest 1/16 pixel, ties toward plus infinity.
    assign tx = oxa_reg + oxb_reg + (60'sd1 <<< 39);
    assign ty = oya_reg + oyb_reg + (60'sd1 <<< 39);

    logic signed [21:0] px;
    logic signed [21:0] py;
    logic signed [19:0] penx_reg;
    logic signed [19:0] peny_reg;

    assign px = 22'(sx_reg) + $signed({4'd0, cx_reg});
    assign py = 22'(sy_reg) + $signed({4'd0, cy_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (px < 22'(hpp_pkg::OUT_MIN))
                penx_reg <= hpp_pkg::OUT_MIN;
            else if (px > 22'(hpp_pkg::OUT_MAX))
                penx_reg <= hpp_pkg::OUT_MAX;
            else
                penx_reg <= px[19:0];
            if (py < 22'(hpp_pkg::OUT_MIN))
                peny_reg <= hpp_pkg::OUT_MIN;
            else if (py > 22'(hpp_pkg::OUT_MAX))
                peny_reg <= hpp_pkg::OUT_MAX;
            else
                peny_reg <= py[19:0];
        end
    end

    assign m_tdata = {peny_reg, penx_reg};

endmodule
